[hdl/ssr_pkg.sv]
// Shared constants and types for the smoothstep remap block.
`timescale 1ns / 1ps
package ssr_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W = 32;
    localparam int NUM_W = 33;

    typedef enum logic [1:0] {
        MODE_SMOOTH   = 2'd0,
        MODE_SMOOTHER = 2'd1,
        MODE_SMOOTHEST = 2'd2,
        MODE_LINEAR   = 2'd3
    } t_mode;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_EDGE_LO = 3'd1;
    localparam logic [2:0] REG_EDGE_HI = 3'd2;
    localparam logic [2:0] REG_OUT_LO  = 3'd3;
    localparam logic [2:0] REG_OUT_HI  = 3'd4;
endpackage

[hdl/ssr_div.sv]
// Pipelined restoring divider: one quotient bit per stage, clamped to 1.0.
`timescale 1ns / 1ps
module ssr_div #(
    parameter int FRAC_BITS = ssr_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [32:0]           i_num,   // magnitude
    input  logic [32:0]           i_den,   // magnitude, nonzero when used
    input  logic                  i_zero,  // force t = 0
    input  logic                  i_one,   // force t = 1.0
    input  logic [1:0]            i_mode,
    output logic                  o_valid,
    output logic [FRAC_BITS:0]    o_t,
    output logic [1:0]            o_mode
);
    // Quotient = floor(num*2^F/den), clamped to 2^F: only F+1 bits needed
    // once num>=den is detected (then t=1.0). Compute F quotient bits in an F+1-bit field.
    localparam int QB = FRAC_BITS + 1;
    localparam int RW = 34;
    logic [RW-1:0]     r_rem [QB+1];
    logic [32:0]       r_den [QB+1];
    logic [QB-1:0]     r_q   [QB+1];
    logic              r_v   [QB+1];
    logic              r_z   [QB+1];
    logic              r_o   [QB+1];
    logic [1:0]        r_m   [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= QB; k++) r_v[k] <= r_v[k-1];
        end
    end

    // stage 0: if num >= den then t saturates to 1.0
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_num};
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_z[0]   <= i_zero;
            r_o[0]   <= i_one || (!i_zero && (i_num >= i_den));
            r_m[0]   <= i_mode;
        end
    end

    // stages 1..QB: num<den so quotient < 2^F; bits F-1..0 over QB-1 steps,
    // last stage just registers.
    for (genvar g = 1; g <= QB; g++) begin : g_st
        logic [RW-1:0] w_sh;
        logic [RW-1:0] w_df;
        assign w_sh = {r_rem[g-1][RW-2:0], 1'b0};
        assign w_df = w_sh - {1'b0, r_den[g-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g] <= r_den[g-1];
                r_z[g]   <= r_z[g-1];
                r_o[g]   <= r_o[g-1];
                r_m[g]   <= r_m[g-1];
                if (g < QB) begin
                    if (!w_df[RW-1]) begin
                        r_rem[g] <= w_df;
                        r_q[g]   <= {r_q[g-1][QB-2:0], 1'b1};
                    end else begin
                        r_rem[g] <= w_sh;
                        r_q[g]   <= {r_q[g-1][QB-2:0], 1'b0};
                    end
                end else begin
                    r_rem[g] <= r_rem[g-1];
                    r_q[g]   <= r_q[g-1];
                end
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_mode  = r_m[QB];
    assign o_t = r_z[QB] ? '0 :
                 r_o[QB] ? (QB)'(1) << FRAC_BITS : r_q[QB];
endmodule

[hdl/smoothstep_remap.sv]
// Top level: normalize, shape and remap one Q15.16 sample per item.
`timescale 1ns / 1ps
// smoothstep_remap
// Slave stream s_axis_* takes one signed sample per item in tdata; master
// stream m_axis_* returns one remapped sample per item. Items flow through a
// pipeline in order; one item may enter every cycle while the output is not stalled.
// Path: stage A, the one-bit-per-stage divider, the six power multiply
// stages and the remap stages S, M and R.
// Throughput: one item per cycle while the pipeline is not stalled.
// Stall: when m_axis_tready is low with a result waiting, the whole pipeline
// holds (s_axis_tready follows the output side), so nothing is lost or
// repeated.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data; always ready.
// Write only while idle. Index 0 mode, 1 and 2 the low and high edges, 3 out low,
// 4 out high; other indexes are dropped.
// Reset (i_rst_n low, synchronous) restores register defaults and empties
// the pipeline.
module smoothstep_remap #(
    parameter int FRAC_BITS = ssr_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sample_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int TW = FRAC_BITS + 1;
    localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

    logic [1:0]  r_mode;
    logic signed [31:0] r_e0, r_e1, r_lo, r_hi;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ssr_pkg::MODE_SMOOTH;
            r_e0 <= '0; r_e1 <= 32'sd65536; r_lo <= '0; r_hi <= 32'sd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ssr_pkg::REG_MODE:    r_mode <= i_cfg_data[1:0];
                ssr_pkg::REG_EDGE_LO: r_e0 <= i_cfg_data;
                ssr_pkg::REG_EDGE_HI: r_e1 <= i_cfg_data;
                ssr_pkg::REG_OUT_LO:  r_lo <= i_cfg_data;
                ssr_pkg::REG_OUT_HI:  r_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global enable: pipeline advances unless the output holds a waiting item
    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage A: num/den, signs and special cases
    logic signed [32:0] w_num, w_den;
    assign w_num = 33'(signed'(s_axis_tdata)) - 33'(r_e0);
    assign w_den = 33'(r_e1) - 33'(r_e0);
    logic r_av, r_az, r_ao;
    logic [32:0] r_an, r_ad;
    logic [1:0] r_am;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (w_en) r_av <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_an <= w_num[32] ? 33'(-w_num) : w_num;
            r_ad <= w_den[32] ? 33'(-w_den) : w_den;
            r_am <= r_mode;
            if (w_den == '0) begin
                r_ao <= signed'(s_axis_tdata) > r_e1;
                r_az <= !(signed'(s_axis_tdata) > r_e1);
            end else begin
                r_ao <= 1'b0;
                r_az <= (w_num == '0) || (w_num[32] != w_den[32]);
            end
        end
    end

    logic w_dv;
    logic [TW-1:0] w_t;
    logic [1:0] w_dm;
    ssr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_av),
        .i_num(r_an), .i_den(r_ad), .i_zero(r_az), .i_one(r_ao),
        .i_mode(r_am), .o_valid(w_dv), .o_t(w_t), .o_mode(w_dm)
    );

    // power chain: stage k holds t^1..t^(k+1)
    logic [TW-1:0] r_p [7][7];   // [stage][power-1]
    logic          r_pv [7];
    logic [1:0]    r_pm [7];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 7; k++) r_pv[k] <= 1'b0;
        end else if (w_en) begin
            r_pv[0] <= w_dv;
            for (int k = 1; k < 7; k++) r_pv[k] <= r_pv[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0][0] <= w_t;
            r_pm[0]   <= w_dm;
            for (int j = 1; j < 7; j++) r_p[0][j] <= '0;
        end
    end
    for (genvar g = 1; g < 7; g++) begin : g_pw
        logic [2*TW-1:0] w_pr;
        assign w_pr = r_p[g-1][g-1] * r_p[g-1][0] + (2*TW)'(ONE >> 1);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int j = 0; j < 7; j++) begin
                    if (j != g) r_p[g][j] <= r_p[g-1][j];
                end
                r_p[g][g] <= w_pr[FRAC_BITS +: TW];
                r_pm[g]   <= r_pm[g-1];
            end
        end
    end

    // stage S: weighted sum and clamp
    localparam int SW = TW + 9;
    logic signed [SW-1:0] w_s, x1, x2, x3, x4, x5, x6, x7;
    assign x1 = SW'(r_p[6][0]); assign x2 = SW'(r_p[6][1]);
    assign x3 = SW'(r_p[6][2]); assign x4 = SW'(r_p[6][3]);
    assign x5 = SW'(r_p[6][4]); assign x6 = SW'(r_p[6][5]);
    assign x7 = SW'(r_p[6][6]);
    always_comb begin
        unique case (r_pm[6])
            ssr_pkg::MODE_SMOOTH:    w_s = SW'(3) * x2 - SW'(2) * x3;
            ssr_pkg::MODE_SMOOTHER:  w_s = SW'(6) * x5 - SW'(15) * x4 + SW'(10) * x3;
            ssr_pkg::MODE_SMOOTHEST: w_s = SW'(-20) * x7 + SW'(70) * x6
                                           - SW'(84) * x5 + SW'(35) * x4;
            default:                 w_s = x1;
        endcase
    end
    logic r_sv;
    logic [TW-1:0] r_s;
    logic signed [32:0] r_sd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv <= 1'b0;
        else if (w_en) r_sv <= r_pv[6];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd <= 33'(r_hi) - 33'(r_lo);
            if (w_s < 0) r_s <= '0;
            else if (w_s > SW'(ONE)) r_s <= ONE;
            else r_s <= w_s[TW-1:0];
        end
    end

    // stage M: product d*s
    localparam int MW = 33 + TW + 1;
    logic r_mv;
    logic signed [MW-1:0] r_mp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv <= 1'b0;
        else if (w_en) r_mv <= r_sv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_mp <= MW'(r_sd) * signed'(MW'({1'b0, r_s}));
    end

    // stage R: round half up (arith shift = floor), add, saturate
    logic signed [MW-1:0] w_pp;
    logic signed [MW-FRAC_BITS-1:0] w_q;
    logic signed [MW-FRAC_BITS:0] w_r;
    assign w_pp = r_mp + MW'(ONE >> 1);
    assign w_q  = w_pp[MW-1:FRAC_BITS];
    assign w_r  = (MW-FRAC_BITS+1)'(w_q) + (MW-FRAC_BITS+1)'(r_lo);
    logic r_ov;
    logic [31:0] r_o;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r_mv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_r > (MW-FRAC_BITS+1)'(64'sd2147483647)) r_o <= 32'h7FFFFFFF;
            else if (w_r < -(MW-FRAC_BITS+1)'(64'sd2147483648)) r_o <= 32'h80000000;
            else r_o <= w_r[31:0];
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_o;
endmodule
